// ----- sv/iir3_pkg.sv -----
// Package for the third-order IIR peripheral: register indexes, control bits,
// filter FSM state type. No dependencies.
package iir3_pkg;
   localparam logic [4:0] REG_VERSION = 5'd0;
   localparam logic [4:0] REG_FORMAT  = 5'd1;
   localparam logic [4:0] REG_CONTROL = 5'd2;
   localparam logic [4:0] REG_STATUS  = 5'd3;
   localparam logic [4:0] REG_INPUT   = 5'd4;
   localparam logic [4:0] REG_OUTPUT  = 5'd5;
   localparam logic [4:0] REG_COEF0   = 5'd6;
   localparam logic [4:0] REG_COEF6   = 5'd12;
   localparam logic [4:0] REG_LOWER   = 5'd13;
   localparam logic [4:0] REG_UPPER   = 5'd14;
   localparam logic [4:0] REG_COUNT   = 5'd15;
   localparam logic [4:0] REG_X1      = 5'd16;
   localparam logic [4:0] REG_X3      = 5'd18;
   localparam logic [4:0] REG_Y1      = 5'd19;
   localparam logic [4:0] REG_Y3      = 5'd21;
   localparam logic [31:0] IIR_VERSION = 32'h0002_0000;
   localparam int CTL_START = 0;
   localparam int CTL_RESET = 1;
   localparam int CTL_CLEAR = 2;
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } fsm_state_type;
endpackage

// ----- sv/iir3_if.sv -----
// Valid/ready channel interfaces for the IIR peripheral.
// Depends on nothing.
interface iir3_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [4:0]  reg_index;
   logic [31:0] write_data;
   modport source (output valid, opcode, reg_index, write_data, input ready);
   modport sink (input valid, opcode, reg_index, write_data, output ready);
endinterface

interface iir3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

// ----- sv/iir_3p3z_limited_peripheral.sv -----
// Top level of the third-order IIR register peripheral.
// Depends on iir3_pkg and the channel interfaces in iir3_if.sv.
//
// A register access is accepted and its response is registered; accesses
// follow back to back while the response slot is free or being taken, except
// that a read of a coefficient or history register holds the request side
// while the RAM read completes. Writing the start bit of control runs the
// filter: coefficients and history sit in one synchronous RAM (one read port),
// so the seven products are formed one per cycle by a single 32x32 multiplier,
// and a start holds the request side while the filter runs: seven coefficient
// reads, a drain of the multiplier and registering of the clamped result, six
// history writebacks and a shift of the history flops. The reset bit of
// control clears the six history entries in RAM, and after reset a clearing
// pass zeroes the coefficient and history entries of the RAM before the first
// item is accepted.
module iir_3p3z_limited_peripheral import iir3_pkg::*; #(
   parameter int FRACTION_BITS = 30
) (
   input logic clock,
   input logic reset,
   iir3_req_if.sink req,
   iir3_rsp_if.source rsp
);
   // RAM map: 0..6 coefficients, 8..10 x1..x3, 11..13 y1..y3
   localparam logic [3:0] MEM_X1 = 4'd8;
   localparam logic [3:0] MEM_Y1 = 4'd11;
   localparam logic [3:0] MEM_TOP = 4'd14;   // one past y3
   localparam int ACC_W = 72;

   logic [31:0] mem [0:15];
   logic [31:0] mem_rd_ff;
   logic [3:0]  mem_wa;
   logic [31:0] mem_wd;
   logic        mem_we;
   logic [3:0]  mem_ra;

   logic [31:0] lower_ff, upper_ff, input_ff, result_ff, count_ff;
   logic        done_ff, sat_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   fsm_state_type state_ff, state_in;
   logic [3:0] step_ff;       // product index issued
   logic [31:0] hist_ff [0:5]; // x1..x3, y1..y3 captured for the shift
   logic        pend_read_ff;
   logic [3:0]  clr_ff;       // clearing countdown, address plus one
   logic        clr_all_ff;   // clear the whole RAM, not only history
   logic [3:0]  rd_step_ff;   // product index of data in mem_rd_ff
   logic        rd_vld_ff;
   logic signed [63:0] prod_ff;
   logic        prod_vld_ff;
   logic        prod_neg_ff;
   logic        prod_last_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [3:0]  wb_ff;        // writeback counter
   logic        mul_last_ff;

   wire accept = req.valid && req.ready;
   wire busy = (state_ff != ST_IDLE) || (clr_ff != 4'd0) || pend_read_ff;
   assign req.ready = !busy && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff;

   wire is_mem_reg = (req.reg_index >= REG_COEF0 && req.reg_index <= REG_COEF6)
      || (req.reg_index >= REG_X1 && req.reg_index <= REG_Y3);
   function automatic logic [3:0] mem_addr(input logic [4:0] idx);
      logic [4:0] a;
      begin
         if (idx <= REG_COEF6) a = idx - REG_COEF0;
         else a = idx - REG_X1 + 5'(MEM_X1);
         return a[3:0];
      end
   endfunction

   wire ctl_wr = accept && req.opcode == OP_WRITE && req.reg_index == REG_CONTROL;
   wire start  = ctl_wr && req.write_data[CTL_START];
   wire clrh   = ctl_wr && req.write_data[CTL_RESET];

   // product operands: step k<7 pairs coefficient k with sample k
   logic [31:0] sample;
   always_comb begin
      case (rd_step_ff)
         4'd0: sample = input_ff;
         4'd1: sample = hist_ff[0];
         4'd2: sample = hist_ff[1];
         4'd3: sample = hist_ff[2];
         4'd4: sample = hist_ff[3];
         4'd5: sample = hist_ff[4];
         4'd6: sample = hist_ff[5];
         default: sample = '0;
      endcase
   end

   // coefficients 0..6 are read in order; samples come from the input register and the history flops
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_MAC;
         ST_MAC:    if (step_ff == 4'd6) state_in = ST_DRAIN;
         ST_DRAIN:  if (mul_last_ff) state_in = ST_FINISH;
         ST_FINISH: if (wb_ff == 4'd6) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // final shift, saturate, clamp
   logic signed [ACC_W-1:0] shifted;
   logic signed [31:0] y_sat, y_fin;
   logic sat_now;
   always_comb begin
      shifted = acc_ff >>> FRACTION_BITS;
      sat_now = 1'b0;
      if (shifted > ACC_W'(64'sd2147483647)) begin
         y_sat = 32'sh7FFF_FFFF; sat_now = 1'b1;
      end else if (shifted < -ACC_W'(64'sd2147483648)) begin
         y_sat = 32'sh8000_0000; sat_now = 1'b1;
      end else begin
         y_sat = shifted[31:0];
      end
      y_fin = y_sat;
      if (y_fin > $signed(upper_ff)) begin
         y_fin = $signed(upper_ff); sat_now = 1'b1;
      end
      if (y_fin < $signed(lower_ff)) begin
         y_fin = $signed(lower_ff); sat_now = 1'b1;
      end
   end

   // memory address and write selection
   always_comb begin
      mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
      mem_ra = mem_addr(req.reg_index);
      if (state_ff == ST_MAC) mem_ra = step_ff;
      if (clr_ff != 4'd0) begin
         mem_we = 1'b1;
         mem_wa = clr_ff - 4'd1;
      end else if (state_ff == ST_FINISH) begin
         mem_we = 1'b1;
         case (wb_ff)
            4'd0: begin mem_wa = MEM_X1;        mem_wd = input_ff;   end
            4'd1: begin mem_wa = MEM_X1 + 4'd1; mem_wd = hist_ff[0]; end
            4'd2: begin mem_wa = MEM_X1 + 4'd2; mem_wd = hist_ff[1]; end
            4'd3: begin mem_wa = MEM_Y1;        mem_wd = result_ff;  end
            4'd4: begin mem_wa = MEM_Y1 + 4'd1; mem_wd = hist_ff[3]; end
            4'd5: begin mem_wa = MEM_Y1 + 4'd2; mem_wd = hist_ff[4]; end
            default: mem_we = 1'b0;
         endcase
      end else if (accept && req.opcode == OP_WRITE && req.reg_index >= REG_COEF0
                   && req.reg_index <= REG_COEF6) begin
         mem_we = 1'b1;
         mem_wa = mem_addr(req.reg_index);
         mem_wd = req.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
   end

   logic [31:0] reg_rd;
   always_comb begin
      case (req.reg_index)
         REG_VERSION: reg_rd = IIR_VERSION;
         REG_FORMAT:  reg_rd = (32'd32 << 8) | 32'(FRACTION_BITS);
         REG_STATUS:  reg_rd = {29'd0, sat_ff, done_ff, 1'b0};
         REG_INPUT:   reg_rd = input_ff;
         REG_OUTPUT:  reg_rd = result_ff;
         REG_LOWER:   reg_rd = lower_ff;
         REG_UPPER:   reg_rd = upper_ff;
         REG_COUNT:   reg_rd = count_ff;
         default:     reg_rd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lower_ff <= 32'h8000_0000;
         upper_ff <= 32'h7FFF_FFFF;
         input_ff <= '0;
         result_ff <= '0;
         count_ff <= '0;
         done_ff <= 1'b0;
         sat_ff <= 1'b0;
         pend_read_ff <= 1'b0;
         clr_ff <= MEM_TOP;      // clear history and coefficients at reset
         clr_all_ff <= 1'b1;
         for (int i = 0; i < 6; i++) hist_ff[i] <= '0;
         step_ff <= '0;
         rd_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         prod_last_ff <= 1'b0;
         mul_last_ff <= 1'b0;
         wb_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (clr_ff != 4'd0) begin
            // stop at x1 unless the whole RAM is being cleared
            if (!clr_all_ff && clr_ff == MEM_X1 + 4'd1) clr_ff <= 4'd0;
            else clr_ff <= clr_ff - 4'd1;
         end
         if (pend_read_ff) begin
            pend_read_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_data_ff <= mem_rd_ff;
         end
         if (accept) begin
            if (req.opcode == OP_READ && is_mem_reg) begin
               pend_read_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff <= (req.opcode == OP_READ) ? reg_rd : '0;
            end
            if (req.opcode == OP_WRITE) begin
               case (req.reg_index)
                  REG_INPUT: input_ff <= req.write_data;
                  REG_LOWER: lower_ff <= req.write_data;
                  REG_UPPER: upper_ff <= req.write_data;
                  REG_CONTROL: begin
                     if (req.write_data[CTL_CLEAR]) done_ff <= 1'b0;
                     if (clrh) begin
                        done_ff <= 1'b0; sat_ff <= 1'b0; count_ff <= '0;
                        for (int i = 0; i < 6; i++) hist_ff[i] <= '0;
                        if (!start) begin
                           clr_ff <= MEM_TOP;
                           clr_all_ff <= 1'b0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         // history is mirrored in flops for the shift; RAM holds copies for reads
         if (start) step_ff <= '0;
         if (state_ff == ST_MAC) step_ff <= step_ff + 4'd1;
         rd_vld_ff <= state_ff == ST_MAC;
         rd_step_ff <= step_ff;
         prod_vld_ff <= rd_vld_ff;
         prod_last_ff <= rd_vld_ff && rd_step_ff == 4'd6;
         mul_last_ff <= prod_vld_ff && prod_last_ff;
         prod_ff <= $signed(mem_rd_ff) * $signed(sample);
         prod_neg_ff <= rd_step_ff >= 4'd4;
         if (start) acc_ff <= '0;
         else if (prod_vld_ff)
            acc_ff <= prod_neg_ff ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
         if (state_ff == ST_DRAIN && mul_last_ff) begin
            result_ff <= y_fin;
            sat_ff <= sat_now;
            done_ff <= 1'b1;
            count_ff <= count_ff + 32'd1;
            wb_ff <= '0;
         end
         if (state_ff == ST_FINISH) begin
            wb_ff <= wb_ff + 4'd1;
            if (wb_ff == 4'd6) begin
               hist_ff[2] <= hist_ff[1];
               hist_ff[1] <= hist_ff[0];
               hist_ff[0] <= input_ff;
               hist_ff[5] <= hist_ff[4];
               hist_ff[4] <= hist_ff[3];
               hist_ff[3] <= result_ff;
            end
         end
      end
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready while filtering");
   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      accept && req.opcode == OP_WRITE |=> rsp_valid_ff && rsp_data_ff == 32'd0)
      else $error("write response not zero");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && $past(state_ff) == ST_DRAIN
      |-> count_ff == $past(count_ff) + 32'd1) else $error("count not advanced");
`endif
endmodule

// ----- tb/tb.sv -----
// Testbench for the third-order IIR register peripheral: register accesses with
// a built-in predictor of the register file and filter arithmetic.
// Depends on iir3_pkg, iir3_if.sv and iir_3p3z_limited_peripheral.
module tb import iir3_pkg::*; ();

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   iir3_req_if req ();
   iir3_rsp_if rsp ();

   iir_3p3z_limited_peripheral uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   // predicted register state
   logic [31:0] coef_q[7];
   logic [31:0] lower_q, upper_q, input_q, output_q, count_q;
   logic [31:0] xhist_q[3], yhist_q[3];
   logic        done_q, sat_q;

   logic [31:0] read_queue[$];
   int          mismatches = 0;
   int          reads_checked = 0;
   int          starts_run = 0;
   longint      cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("timeout waiting for responses");
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%s at cycle %0d: read_data %h, expected %h", what, cycle_count, got, want);
   endtask

   function automatic void clear_history();
      for (int i = 0; i < 3; i++) begin
         xhist_q[i] = '0;
         yhist_q[i] = '0;
      end
      done_q = 1'b0;
      sat_q = 1'b0;
      count_q = '0;
   endfunction

   function automatic void reset_registers();
      for (int i = 0; i < 7; i++) coef_q[i] = '0;
      lower_q = 32'h8000_0000;
      upper_q = 32'h7FFF_FFFF;
      input_q = '0;
      output_q = '0;
      clear_history();
   endfunction

   function automatic void filter_sample();
      logic signed [127:0] acc, shifted;
      logic signed [63:0]  y;
      logic                sat;
      sat = 1'b0;
      acc = 128'(signed'(coef_q[0])) * 128'(signed'(input_q));
      for (int i = 0; i < 3; i++) begin
         acc += 128'(signed'(coef_q[1 + i])) * 128'(signed'(xhist_q[i]));
         acc -= 128'(signed'(coef_q[4 + i])) * 128'(signed'(yhist_q[i]));
      end
      shifted = acc >>> 30;
      if (shifted > 128'sd2147483647) begin
         y = 64'sd2147483647;
         sat = 1'b1;
      end else if (shifted < -128'sd2147483648) begin
         y = -64'sd2147483648;
         sat = 1'b1;
      end else begin
         y = 64'(shifted);
      end
      if (y > 64'(signed'(upper_q))) begin
         y = 64'(signed'(upper_q));
         sat = 1'b1;
      end
      if (y < 64'(signed'(lower_q))) begin
         y = 64'(signed'(lower_q));
         sat = 1'b1;
      end
      output_q = y[31:0];
      xhist_q[2] = xhist_q[1];
      xhist_q[1] = xhist_q[0];
      xhist_q[0] = input_q;
      yhist_q[2] = yhist_q[1];
      yhist_q[1] = yhist_q[0];
      yhist_q[0] = output_q;
      done_q = 1'b1;
      sat_q = sat;
      count_q++;
      starts_run++;
   endfunction

   function automatic logic [31:0] register_value(input logic [4:0] idx);
      case (idx)
         REG_VERSION: return IIR_VERSION;
         REG_FORMAT:  return (32'd32 << 8) | 32'd30;
         REG_STATUS:  return {29'd0, sat_q, done_q, 1'b0};
         REG_INPUT:   return input_q;
         REG_OUTPUT:  return output_q;
         REG_LOWER:   return lower_q;
         REG_UPPER:   return upper_q;
         REG_COUNT:   return count_q;
         default: begin
            if (idx >= REG_COEF0 && idx <= REG_COEF6) return coef_q[idx - REG_COEF0];
            if (idx >= REG_X1 && idx <= REG_X3) return xhist_q[idx - REG_X1];
            if (idx >= REG_Y1 && idx <= REG_Y3) return yhist_q[idx - REG_Y1];
            return '0;
         end
      endcase
   endfunction

   function automatic logic [31:0] apply_access(input logic op, input logic [4:0] idx,
                                                input logic [31:0] data);
      if (op == OP_READ) return register_value(idx);
      if (idx == REG_CONTROL) begin
         if (data[CTL_CLEAR]) done_q = 1'b0;
         if (data[CTL_RESET]) clear_history();
         if (data[CTL_START]) filter_sample();
      end else if (idx == REG_INPUT) begin
         input_q = data;
      end else if (idx >= REG_COEF0 && idx <= REG_COEF6) begin
         coef_q[idx - REG_COEF0] = data;
      end else if (idx == REG_LOWER) begin
         lower_q = data;
      end else if (idx == REG_UPPER) begin
         upper_q = data;
      end
      return '0;
   endfunction

   task automatic send_access(input logic op, input logic [4:0] idx, input logic [31:0] data);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.reg_index <= idx;
      req.write_data <= data;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      read_queue.push_back(apply_access(op, idx, data));
   endtask

   // response side: random stalls, compare each item with the oldest prediction
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         if (read_queue.size() == 0) begin
            report_mismatch("unexpected response", rsp.read_data, '0);
         end else begin
            if (rsp.read_data !== read_queue[0])
               report_mismatch("mismatch", rsp.read_data, read_queue[0]);
            void'(read_queue.pop_front());
            reads_checked++;
         end
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 4096) - 2048;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_identity_and_unknown();
      for (int i = 0; i < 32; i++) send_access(OP_READ, 5'(i), $urandom());
      send_access(OP_WRITE, REG_VERSION, 32'hFFFF_FFFF);
      send_access(OP_WRITE, REG_COUNT, 32'hFFFF_FFFF);
      send_access(OP_WRITE, 5'd31, 32'hFFFF_FFFF);
      send_access(OP_READ, REG_VERSION, '0);
      send_access(OP_READ, REG_COUNT, '0);
   endtask

   task automatic test_extreme_filter();
      // full-scale gains, b0 just under two and a feedback pole: saturate both ways
      send_access(OP_WRITE, REG_COEF0, 32'h7FFF_FFFF);
      send_access(OP_WRITE, REG_COEF0 + 5'd1, 32'h8000_0000);
      send_access(OP_WRITE, REG_COEF0 + 5'd4, 32'h8000_0000);
      send_access(OP_WRITE, REG_INPUT, 32'h7FFF_FFFF);
      send_access(OP_WRITE, REG_CONTROL, 32'h1);
      send_access(OP_READ, REG_STATUS, '0);
      send_access(OP_WRITE, REG_INPUT, 32'h8000_0000);
      send_access(OP_WRITE, REG_CONTROL, 32'h1);
      send_access(OP_READ, REG_OUTPUT, '0);
      // inverted limits force the lower one
      send_access(OP_WRITE, REG_LOWER, 32'd100);
      send_access(OP_WRITE, REG_UPPER, 32'hFFFF_FF00);
      send_access(OP_WRITE, REG_CONTROL, 32'h1);
      send_access(OP_READ, REG_OUTPUT, '0);
      send_access(OP_WRITE, REG_CONTROL, 32'h7);
      send_access(OP_READ, REG_STATUS, '0);
      send_access(OP_WRITE, REG_CONTROL, 32'h4);
      send_access(OP_WRITE, REG_CONTROL, 32'h2);
      send_access(OP_READ, REG_COUNT, '0);
   endtask

   task automatic test_random_samples(input int n);
      logic [4:0] idx;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               send_access(OP_WRITE, REG_INPUT, random_word());
               send_access(OP_WRITE, REG_CONTROL, 32'h1);
               send_access(OP_READ, 5'($urandom_range(3, 21)), '0);
            end
            2: send_access(OP_WRITE, 5'($urandom_range(6, 12)),
                           $urandom_range(0, 1) ? random_word() : $urandom_range(0, 1 << 29));
            3: send_access(OP_WRITE, 5'($urandom_range(13, 14)), random_word());
            4: send_access(OP_WRITE, REG_CONTROL,
                           ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 7)));
            5: begin
               idx = 5'($urandom());
               send_access(OP_WRITE, idx, $urandom());
            end
            default: send_access(OP_READ, 5'($urandom()), $urandom());
         endcase
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.opcode = OP_READ;
      req.reg_index = '0;
      req.write_data = '0;
      reset_registers();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_and_unknown();
      test_extreme_filter();
      test_random_samples(330);
      req.valid <= 1'b0;
      while (read_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("checked %0d responses over %0d filter runs", reads_checked, starts_run);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
